/* sv/unc_pkg.sv */
// ----------------------------------------------------------------------------
// unc_pkg: shared types and constants of the node renumbering unit
// Field widths, opcodes, the node_count reset value and the bitmap control group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package unc_pkg;

   localparam int NODE_W   = 12;
   localparam int CLASS_W  = 1;
   localparam int VALUE_W  = 13;
   localparam int RANK_W   = 12;

   localparam int DEF_MAX_NODES   = 4096;
   localparam int DEF_NUM_CLASSES = 2;

   localparam logic [VALUE_W-1:0] NODE_COUNT_RESET = 13'd4096;

   typedef enum logic [1:0] {
      OP_MARK   = 2'd0,
      OP_BUILD  = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // Control group from the sequencer to the used-node bitmap.
   typedef struct packed {
      logic wr_en;
      logic clear;
      logic rd_en;
   } bm_ctl_type;

endpackage

/* sv/used_node_compact_renumber_unit.sv */
// ----------------------------------------------------------------------------
// used_node_compact_renumber_unit: dense per-class node renumbering
// Marks nodes in a used-node bitmap, builds dense ranks per class by a
// sequential scan, and answers rank lookups.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_op, req_node_class,
//                                               req_node_index
//   rsp_      out        rsp_valid / rsp_stall  rsp_value, rsp_is_count,
//                                               rsp_not_marked
//   csr_      in         csr_wr_en              csr_wr_data (node_count)
//
// A mark writes the bitmap and leaves the unit in idle. A lookup runs a
// bitmap and rank read, then result forming, then the output load. A build is
// paced by the scan counter that walks the bitmap read port one node per cycle
// up to min(node_count, MAX_NODES), then waits for the last node's bit.
// A clear writes one bitmap word a cycle across all MAX_NODES words.
// After reset the same clearing pass runs over every word with req_stall
// high; csr writes are taken throughout. A result waiting under rsp_stall
// holds the unit in its last state, while marks and clears may still enter
// once the unit is back in idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module used_node_compact_renumber_unit import unc_pkg::*; #(
   parameter int MAX_NODES   = DEF_MAX_NODES,
   parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [CLASS_W-1:0] req_node_class,
   input  logic [NODE_W-1:0]  req_node_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_value,
   output logic               rsp_is_count,
   output logic               rsp_not_marked,
   input  logic               csr_wr_en,
   input  logic [VALUE_W-1:0] csr_wr_data
);

   localparam int AW  = $clog2(MAX_NODES);
   localparam int CLW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int RAW = CLW + AW;
   // The scan index must hold both node_count and MAX_NODES.
   localparam int LW  = (AW + 1 > VALUE_W) ? AW + 1 : VALUE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLR,
      S_BUILD,
      S_LOOK,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [LW-1:0]      idx_ff, idx_in;
   logic [VALUE_W-1:0] cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_idx_ff, pend_idx_in;
   logic [CLW-1:0]     cls_ff, cls_in;
   logic               cls_ok_ff, cls_ok_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic               res_nm_ff, res_nm_in;
   logic               res_cnt_ff, res_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_is_count_ff, rsp_is_count_in;
   logic               rsp_not_marked_ff, rsp_not_marked_in;
   logic [VALUE_W-1:0] node_count_ff, node_count_in;

   logic                   req_accept;
   op_type                 req_op_e;
   logic                   req_cls_ok;
   logic [CLW-1:0]         req_cls;
   logic [LW-1:0]          lim;
   logic                   scan_go;

   bm_ctl_type             bm_ctl;
   logic [AW-1:0]          bm_wr_addr;
   logic [CLW-1:0]         bm_wr_cls;
   logic [AW-1:0]          bm_rd_addr;
   logic [NUM_CLASSES-1:0] bm_rd_data;

   logic                   rk_wr_en;
   logic [RAW-1:0]         rk_wr_addr;
   logic [RANK_W-1:0]      rk_wr_data;
   logic                   rk_rd_en;
   logic [RAW-1:0]         rk_rd_addr;
   logic [RANK_W-1:0]      rk_rd_data;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_op_e   = op_type'(req_op);
   assign req_cls_ok = (int'(req_node_class) < NUM_CLASSES);
   assign req_cls    = CLW'(req_node_class);

   // A node_count above the array depth scans the whole array.
   assign lim = (LW'(node_count_ff) > LW'(MAX_NODES)) ? LW'(MAX_NODES)
                                                       : LW'(node_count_ff);

   // A build for a class that does not exist scans nothing and counts zero.
   assign scan_go = cls_ok_ff && (idx_ff < lim);

   always_comb begin
      state_in          = state_ff;
      idx_in            = idx_ff;
      cnt_in            = cnt_ff;
      pend_in           = 1'b0;
      pend_idx_in       = pend_idx_ff;
      cls_in            = cls_ff;
      cls_ok_in         = cls_ok_ff;
      node_in           = node_ff;
      res_value_in      = res_value_ff;
      res_nm_in         = res_nm_ff;
      res_cnt_in        = res_cnt_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_value_in      = rsp_value_ff;
      rsp_is_count_in   = rsp_is_count_ff;
      rsp_not_marked_in = rsp_not_marked_ff;
      node_count_in     = csr_wr_en ? csr_wr_data : node_count_ff;

      bm_ctl     = '0;
      bm_wr_addr = '0;
      bm_wr_cls  = req_cls;
      bm_rd_addr = '0;
      rk_wr_en   = 1'b0;
      rk_wr_addr = {cls_ff, pend_idx_ff};
      rk_wr_data = cnt_ff[RANK_W-1:0];
      rk_rd_en   = 1'b0;
      rk_rd_addr = {req_cls, AW'(req_node_index)};

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cls_in    = req_cls;
               cls_ok_in = req_cls_ok;
               node_in   = req_node_index;
               unique case (req_op_e)
                  OP_MARK: begin
                     // Marks outside the array or the class range are dropped.
                     if (req_cls_ok && (int'(req_node_index) < MAX_NODES)) begin
                        bm_ctl.wr_en = 1'b1;
                        bm_wr_addr   = AW'(req_node_index);
                     end
                  end
                  OP_BUILD: begin
                     idx_in   = '0;
                     cnt_in   = '0;
                     state_in = S_BUILD;
                  end
                  OP_LOOKUP: begin
                     bm_ctl.rd_en = 1'b1;
                     bm_rd_addr   = AW'(req_node_index);
                     rk_rd_en     = 1'b1;
                     state_in     = S_LOOK;
                  end
                  OP_CLEAR: begin
                     idx_in   = '0;
                     state_in = S_CLR;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_CLR: begin
            bm_ctl.wr_en = 1'b1;
            bm_ctl.clear = 1'b1;
            bm_wr_addr   = AW'(idx_ff);
            idx_in       = idx_ff + LW'(1);
            if (idx_ff == LW'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_BUILD: begin
            // Read node idx this cycle; its bit returns next cycle as pend.
            if (scan_go) begin
               bm_ctl.rd_en = 1'b1;
               bm_rd_addr   = AW'(idx_ff);
               idx_in       = idx_ff + LW'(1);
               pend_in      = 1'b1;
               pend_idx_in  = AW'(idx_ff);
            end
            if (pend_ff && bm_rd_data[cls_ff]) begin
               rk_wr_en = 1'b1;
               cnt_in   = cnt_ff + VALUE_W'(1);
            end
            if (!scan_go && !pend_ff) begin
               res_value_in = cnt_ff;
               res_nm_in    = 1'b0;
               res_cnt_in   = 1'b1;
               state_in     = S_DONE;
            end
         end

         S_LOOK: begin
            if (cls_ok_ff && (LW'(node_ff) < lim) && bm_rd_data[cls_ff]) begin
               res_value_in = VALUE_W'(rk_rd_data);
               res_nm_in    = 1'b0;
            end else begin
               res_value_in = '0;
               res_nm_in    = 1'b1;
            end
            res_cnt_in = 1'b0;
            state_in   = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_value_in      = res_value_ff;
               rsp_is_count_in   = res_cnt_ff;
               rsp_not_marked_in = res_nm_ff;
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
      end
      cnt_ff            <= cnt_in;
      pend_idx_ff       <= pend_idx_in;
      cls_ff            <= cls_in;
      cls_ok_ff         <= cls_ok_in;
      node_ff           <= node_in;
      res_value_ff      <= res_value_in;
      res_nm_ff         <= res_nm_in;
      res_cnt_ff        <= res_cnt_in;
      rsp_value_ff      <= rsp_value_in;
      rsp_is_count_ff   <= rsp_is_count_in;
      rsp_not_marked_ff <= rsp_not_marked_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_is_count   = rsp_is_count_ff;
   assign rsp_not_marked = rsp_not_marked_ff;

   unc_bitmap #(
      .MAX_NODES   (MAX_NODES),
      .NUM_CLASSES (NUM_CLASSES)
   ) u_bitmap (
      .clock   (clock),
      .ctl     (bm_ctl),
      .wr_addr (bm_wr_addr),
      .wr_cls  (bm_wr_cls),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   unc_rank_mem #(
      .MAX_NODES   (MAX_NODES),
      .NUM_CLASSES (NUM_CLASSES)
   ) u_rank_mem (
      .clock   (clock),
      .wr_en   (rk_wr_en),
      .wr_addr (rk_wr_addr),
      .wr_data (rk_wr_data),
      .rd_en   (rk_rd_en),
      .rd_addr (rk_rd_addr),
      .rd_data (rk_rd_data)
   );

`ifndef ASSERT_OFF
   // An accepted lookup always moves on to forming its result.
   a_lookup_next: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_op_e == OP_LOOKUP) |=> (state_ff == S_LOOK))
      else $error("lookup did not enter the result state");

   // Rank entries are written only by the build scan.
   a_rank_wr_build: assert property (@(posedge clock) disable iff (reset)
      rk_wr_en |-> (state_ff == S_BUILD))
      else $error("rank table written outside a build");

   // The dense count never runs past the scanned range.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BUILD) |-> (LW'(cnt_ff) <= idx_ff))
      else $error("build count exceeds scanned nodes");

   // A pending bitmap bit exists only inside a build.
   a_pend_build: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_BUILD))
      else $error("pending scan bit outside a build");

   // A waiting result is never overwritten by the next one.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_value_ff))
      else $error("waiting result was overwritten");
`endif

endmodule

/* sv/unc_bitmap.sv */
// ----------------------------------------------------------------------------
// unc_bitmap: used-node bitmap memory
// One word per node with one bit per class; bit set or word clear on the
// write port, registered word read on the read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unc_bitmap import unc_pkg::*; #(
   parameter int MAX_NODES   = DEF_MAX_NODES,
   parameter int NUM_CLASSES = DEF_NUM_CLASSES,
   localparam int AW  = $clog2(MAX_NODES),
   localparam int CLW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
   input  logic                   clock,
   input  bm_ctl_type             ctl,
   input  logic [AW-1:0]          wr_addr,
   input  logic [CLW-1:0]         wr_cls,
   input  logic [AW-1:0]          rd_addr,
   output logic [NUM_CLASSES-1:0] rd_data
);

   logic [NUM_CLASSES-1:0] mem_ff [MAX_NODES];
   logic [NUM_CLASSES-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         if (ctl.clear) begin
            mem_ff[wr_addr] <= '0;
         end else begin
            mem_ff[wr_addr][wr_cls] <= 1'b1;
         end
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/unc_rank_mem.sv */
// ----------------------------------------------------------------------------
// unc_rank_mem: dense rank table
// One entry per class and node, addressed as class then node; written by
// the build scan, read with a registered output by lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unc_rank_mem import unc_pkg::*; #(
   parameter int MAX_NODES   = DEF_MAX_NODES,
   parameter int NUM_CLASSES = DEF_NUM_CLASSES,
   localparam int AW    = $clog2(MAX_NODES),
   localparam int CLW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
   localparam int RAW   = CLW + AW,
   localparam int DEPTH = NUM_CLASSES * (2 ** AW)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [RAW-1:0]    wr_addr,
   input  logic [RANK_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [RAW-1:0]    rd_addr,
   output logic [RANK_W-1:0] rd_data
);

   logic [RANK_W-1:0] mem_ff [DEPTH];
   logic [RANK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
